@@ rtl/hpq_pkg.sv @@
package hpq_pkg;

  // default sizing
  localparam int HPQ_CAPACITY  = 128;
  localparam int HPQ_KEY_WIDTH = 32;

  // fixed port widths
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 8;
  localparam int STATUS_W = 2;

  // request opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic ins_start;
    logic rm_start;
    logic set_full;
    logic set_empty;
    logic rd_parent;
    logic rd_left;
    logic rd_right;
    logic cap_left;
    logic load_last;
    logic write_cur;
    logic move_up;
    logic move_down;
    logic load_result;
  } hpq_cmd_t;

  // flags from the datapath to the controller
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic is_root;
    logic no_left;
    logic has_right;
    logic up_greater;
    logic down_smaller;
  } hpq_stat_t;

endpackage

@@ rtl/hpq_ctrl.sv @@
module hpq_ctrl import hpq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      opcode_i,
  input  logic      out_ready_i,
  input  hpq_stat_t stat_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output hpq_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_RD   = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_LAST_WT = 4'd3;
  localparam logic [3:0] S_DN_RDL  = 4'd4;
  localparam logic [3:0] S_DN_RDR  = 4'd5;
  localparam logic [3:0] S_DN_CMP  = 4'd6;
  localparam logic [3:0] S_DONE    = 4'd7;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (opcode_i == OP_INSERT) begin
            if (stat_i.cnt_full) begin
              cmd_o.set_full = 1'b1;
              state_d        = S_DONE;
            end else begin
              cmd_o.ins_start = 1'b1;
              state_d         = S_UP_RD;
            end
          end else begin
            if (stat_i.cnt_zero) begin
              cmd_o.set_empty = 1'b1;
              state_d         = S_DONE;
            end else begin
              cmd_o.rm_start = 1'b1;
              state_d        = S_LAST_WT;
            end
          end
        end
      end
      S_UP_RD: begin
        if (stat_i.is_root) begin
          cmd_o.write_cur = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.rd_parent = 1'b1;
          state_d         = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat_i.up_greater) begin
          cmd_o.move_up = 1'b1;
          state_d       = S_UP_RD;
        end else begin
          cmd_o.write_cur = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_LAST_WT: begin
        cmd_o.load_last = 1'b1;
        state_d         = stat_i.cnt_zero ? S_DONE : S_DN_RDL;
      end
      S_DN_RDL: begin
        if (stat_i.no_left) begin
          cmd_o.write_cur = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.rd_left = 1'b1;
          state_d       = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        cmd_o.cap_left = 1'b1;
        cmd_o.rd_right = stat_i.has_right;
        state_d        = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat_i.down_smaller) begin
          cmd_o.move_down = 1'b1;
          state_d         = S_DN_RDL;
        end else begin
          cmd_o.write_cur = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.load_result = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/hpq_dp.sv @@
module hpq_dp import hpq_pkg::*; #(
  parameter int CAPACITY  = HPQ_CAPACITY,
  parameter int KEY_WIDTH = HPQ_KEY_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hpq_cmd_t                   cmd_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  output hpq_stat_t                  stat_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic signed [VALUE_W-1:0]  removed_value_o,
  output logic [COUNT_W-1:0]         count_o,
  output logic signed [VALUE_W-1:0]  top_value_o
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int POS_W  = $clog2(CAPACITY + 1);
  localparam int EXT_W  = (KEY_WIDTH > VALUE_W) ? KEY_WIDTH : VALUE_W;

  typedef logic signed [KEY_WIDTH-1:0] key_t;

  // sign-extend a key and keep the port width
  function automatic logic [VALUE_W-1:0] key_to_port(input key_t k);
    logic [EXT_W:0] w;
    w = {{(EXT_W - KEY_WIDTH + 1){k[KEY_WIDTH-1]}}, k};
    return w[VALUE_W-1:0];
  endfunction

  key_t              mem_q [CAPACITY];
  key_t              rdata_q;
  key_t              cur_q, left_q, top_q, removed_q;
  logic [POS_W-1:0]  cnt_q, pos_q;
  logic [STATUS_W-1:0] st_q;

  logic [STATUS_W-1:0] res_status_q;
  logic [VALUE_W-1:0]  res_removed_q, res_top_q;
  logic [COUNT_W-1:0]  res_count_q;

  key_t              in_key, pick_val, wr_data;
  logic [POS_W:0]    left_pos, right_pos, pick_pos, rd_pos;
  logic [POS_W:0]    rd_idx, wr_idx;
  logic              pick_right, rd_en, wr_en;

  assign in_key    = KEY_WIDTH'({{(EXT_W - VALUE_W + 1){1'b0}}, value_i});
  assign left_pos  = {pos_q, 1'b0};
  assign right_pos = {pos_q, 1'b1};

  // larger child, left wins a tie
  assign pick_right = stat_o.has_right && (rdata_q > left_q);
  assign pick_val   = pick_right ? rdata_q : left_q;
  assign pick_pos   = pick_right ? right_pos : left_pos;

  // flags for the controller
  always_comb begin
    stat_o.cnt_zero     = (cnt_q == '0);
    stat_o.cnt_full     = (cnt_q == POS_W'(CAPACITY));
    stat_o.is_root      = (pos_q == POS_W'(1));
    stat_o.no_left      = (left_pos > {1'b0, cnt_q});
    stat_o.has_right    = (right_pos <= {1'b0, cnt_q});
    stat_o.up_greater   = (cur_q > rdata_q);
    stat_o.down_smaller = (cur_q < pick_val);
  end

  // read address select
  always_comb begin
    rd_en  = cmd_i.rm_start | cmd_i.rd_parent | cmd_i.rd_left | cmd_i.rd_right;
    rd_pos = {1'b0, cnt_q};
    if (cmd_i.rd_parent) begin
      rd_pos = {2'b00, pos_q[POS_W-1:1]};
    end else if (cmd_i.rd_left) begin
      rd_pos = left_pos;
    end else if (cmd_i.rd_right) begin
      rd_pos = right_pos;
    end
    rd_idx = rd_pos - 1'b1;
  end

  // write select, the moving key stays in a register until it lands
  always_comb begin
    wr_en   = cmd_i.write_cur | cmd_i.move_up | cmd_i.move_down;
    wr_data = cur_q;
    if (cmd_i.move_up) begin
      wr_data = rdata_q;
    end else if (cmd_i.move_down) begin
      wr_data = pick_val;
    end
    wr_idx = {1'b0, pos_q} - 1'b1;
  end

  // heap store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx[ADDR_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_idx[ADDR_W-1:0]];
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_q     <= in_key;
      removed_q <= '0;
      st_q      <= ST_OK;
    end
    if (cmd_i.set_full) begin
      st_q <= ST_FULL;
    end
    if (cmd_i.set_empty) begin
      st_q <= ST_EMPTY;
    end
    if (cmd_i.rm_start) begin
      removed_q <= top_q;
    end
    if (cmd_i.cap_left) begin
      left_q <= rdata_q;
    end
    if (cmd_i.load_last) begin
      cur_q <= rdata_q;
    end
    if (wr_en && pos_q == POS_W'(1)) begin
      top_q <= wr_data;
    end
  end

  // position along the sift path
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_start) begin
      pos_q <= cnt_q + 1'b1;
    end else if (cmd_i.load_last) begin
      pos_q <= POS_W'(1);
    end else if (cmd_i.move_up) begin
      pos_q <= pos_q >> 1;
    end else if (cmd_i.move_down) begin
      pos_q <= pick_pos[POS_W-1:0];
    end
  end

  // live entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.ins_start) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (cmd_i.rm_start) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // result register, holds while the next request runs
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      res_status_q  <= st_q;
      res_removed_q <= key_to_port(removed_q);
      res_count_q   <= COUNT_W'(cnt_q);
      res_top_q     <= (cnt_q == '0) ? '0 : key_to_port(top_q);
    end
  end

  assign status_o        = res_status_q;
  assign removed_value_o = res_removed_q;
  assign count_o         = res_count_q;
  assign top_value_o     = res_top_q;

endmodule

@@ rtl/max_heap_priority_queue.sv @@
// Binary max-heap priority queue with a valid/ready request channel and a
// valid/ready result channel; every request (insert or remove-max) returns
// one result with status, removed key, entry count and current maximum.
// Requests run one at a time, limited by the single read port of the heap
// store: an insert reads and compares one parent per level climbed; a
// remove moves the last entry to the root, then reads the children and
// compares per level descended. Failed requests (remove when empty, insert
// when full) change nothing. A result waits in an output register, so the
// next request is taken while it is not yet consumed. No clearing pass is
// needed after reset.
module max_heap_priority_queue import hpq_pkg::*; #(
  parameter int CAPACITY  = HPQ_CAPACITY,
  parameter int KEY_WIDTH = HPQ_KEY_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      opcode_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic signed [VALUE_W-1:0] removed_value_o,
  output logic [COUNT_W-1:0]        count_o,
  output logic signed [VALUE_W-1:0] top_value_o
);

  hpq_cmd_t  cmd;
  hpq_stat_t stat;

  // sequencer
  hpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (opcode_i),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // store and working registers
  hpq_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .value_i         (value_i),
    .stat_o          (stat),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .count_o         (count_o),
    .top_value_o     (top_value_o)
  );

  // remove from an empty heap leaves it empty and reports zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |->
      count_o == '0 && top_value_o == '0 && removed_value_o == '0)
    else $error("empty remove result inconsistent");

  // insert into a full heap reports the full count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |->
      count_o == COUNT_W'(CAPACITY) && removed_value_o == '0)
    else $error("full insert result inconsistent");

  // an empty heap shows no maximum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && count_o == '0 && CAPACITY < (1 << COUNT_W) |->
      top_value_o == '0)
    else $error("top value shown on empty heap");

endmodule
